>>> src/assert_macros.svh
// Assertion macros for the RTL.
// ASSERT_PROP checks a clocked property, ASSERT_NEVER checks that an expression never holds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> src/mvsm_pkg.sv
`timescale 1ns / 1ps
package mvsm_pkg;

    localparam int OP_W       = 2;
    localparam int VOICE_W    = 3;
    localparam int ADDR_W     = 16;
    localparam int LEN_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int CFG_W      = 4;
    localparam int MASK_W     = 8;
    localparam int GAIN_SHIFT = 12;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

    localparam logic [LEN_W-1:0] LEN_MAX      = 17'h10000;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_MIX   = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef struct packed {
        logic loop;
        logic right;
        logic left;
    } voice_flags_t;

    typedef struct packed {
        logic [ADDR_W-1:0] position;
        logic [LEN_W-1:0]  remaining;
        logic [ADDR_W-1:0] region_start;
        logic [LEN_W-1:0]  region_length;
        logic [GAIN_W-1:0] gain;
        voice_flags_t      flags;
    } voice_rec_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] mix_left_out;
        logic signed [ACC_W-1:0] mix_right_out;
        logic [MASK_W-1:0]       playing_mask;
    } result_t;

endpackage

>>> src/mvsm_if.sv
`timescale 1ns / 1ps
interface mvsm_in_if;
    logic                                      valid;
    logic                                      ready;
    mvsm_pkg::op_t                             op;
    logic [mvsm_pkg::VOICE_W-1:0]              voice;
    logic [mvsm_pkg::ADDR_W-1:0]               address;
    logic [mvsm_pkg::LEN_W-1:0]                length;
    logic [mvsm_pkg::GAIN_W-1:0]               gain;
    logic                                      route_left;
    logic                                      route_right;
    logic                                      looping;
    logic signed [mvsm_pkg::SAMPLE_W-1:0]      sample_word;
    logic signed [mvsm_pkg::ACC_W-1:0]         mix_left_in;
    logic signed [mvsm_pkg::ACC_W-1:0]         mix_right_in;

    modport source (
        output valid, op, voice, address, length, gain, route_left, route_right, looping,
        output sample_word, mix_left_in, mix_right_in,
        input  ready
    );
    modport sink (
        input  valid, op, voice, address, length, gain, route_left, route_right, looping,
        input  sample_word, mix_left_in, mix_right_in,
        output ready
    );
endinterface

interface mvsm_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mvsm_pkg::ACC_W-1:0]         mix_left_out;
    logic signed [mvsm_pkg::ACC_W-1:0]         mix_right_out;
    logic [mvsm_pkg::MASK_W-1:0]               playing_mask;

    modport source (
        output valid, mix_left_out, mix_right_out, playing_mask,
        input  ready
    );
    modport sink (
        input  valid, mix_left_out, mix_right_out, playing_mask,
        output ready
    );
endinterface

>>> src/mvsm_sample_mem.sv
`timescale 1ns / 1ps
module mvsm_sample_mem #(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic [mvsm_pkg::SAMPLE_W-1:0]    wdata,
    input  logic                             re,
    input  logic [AW-1:0]                    raddr,
    output logic [mvsm_pkg::SAMPLE_W-1:0]    rdata
);
    import mvsm_pkg::*;

    logic [SAMPLE_W-1:0] word_mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            word_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= word_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mvsm_voice_mem.sv
`timescale 1ns / 1ps
module mvsm_voice_mem #(
    parameter int VOICES = 8,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [VW-1:0]           waddr,
    input  mvsm_pkg::voice_rec_t    wdata,
    input  logic                    re,
    input  logic [VW-1:0]           raddr,
    output mvsm_pkg::voice_rec_t    rdata
);
    import mvsm_pkg::*;

    voice_rec_t rec_mem [VOICES];
    voice_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rec_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= rec_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mvsm_engine.sv
`timescale 1ns / 1ps
module mvsm_engine #(
    parameter int VOICES = 8,
    parameter int SAMPLE_DEPTH = 65536,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int AW = $clog2(SAMPLE_DEPTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mvsm_in_if.sink                          item,
    input  logic [mvsm_pkg::CFG_W-1:0]       active_voices,
    output logic                             sm_we,
    output logic [AW-1:0]                    sm_waddr,
    output logic [mvsm_pkg::SAMPLE_W-1:0]    sm_wdata,
    output logic                             sm_re,
    output logic [AW-1:0]                    sm_raddr,
    input  logic [mvsm_pkg::SAMPLE_W-1:0]    sm_rdata,
    output logic                             vm_we,
    output logic [VW-1:0]                    vm_waddr,
    output mvsm_pkg::voice_rec_t             vm_wdata,
    output logic                             vm_re,
    output logic [VW-1:0]                    vm_raddr,
    input  mvsm_pkg::voice_rec_t             vm_rdata,
    output logic                             res_valid,
    input  logic                             res_ready,
    output mvsm_pkg::result_t                res
);
    import mvsm_pkg::*;

    localparam int  CW         = $clog2(VOICES + 1);
    localparam bit  DEPTH_POW2 = (SAMPLE_DEPTH & (SAMPLE_DEPTH - 1)) == 0;
    // Addresses wrap modulo the memory depth. For a depth that is not a power of two and
    // below the 16-bit address range, the wrap is a restoring reduction, one bit a cycle.
    localparam int  MOD_STEPS  = (DEPTH_POW2 || SAMPLE_DEPTH >= 65536) ? 0 : 17 - AW;
    localparam int  SW         = $clog2(MOD_STEPS + 2);
    localparam int  RED_TOP_I  = SAMPLE_DEPTH << ((MOD_STEPS > 0) ? MOD_STEPS - 1 : 0);
    localparam logic [ADDR_W-1:0] RED_TOP = ADDR_W'(RED_TOP_I);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_VWAIT,
        S_REDUCE,
        S_SREQ,
        S_SWRITE,
        S_SDATA,
        S_ACC,
        S_RESULT
    } state_t;

    state_t                      state_reg, state_next;
    logic [VOICES-1:0]           playing_reg, playing_next;
    op_t                         op_reg, op_next;
    logic [VOICE_W-1:0]          voice_reg, voice_next;
    logic [ADDR_W-1:0]           addr_reg, addr_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [GAIN_W-1:0]           gain_reg, gain_next;
    voice_flags_t                flags_reg, flags_next;
    logic [SAMPLE_W-1:0]         word_reg, word_next;
    logic signed [ACC_W-1:0]     acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0]     acc_r_reg, acc_r_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [ADDR_W-1:0]           red_reg, red_next;
    logic [ADDR_W-1:0]           red_sub_reg, red_sub_next;
    logic [SW-1:0]               red_cnt_reg, red_cnt_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;

    logic                        voice_ok;
    logic [VW-1:0]               vidx;
    voice_rec_t                  start_rec;
    voice_rec_t                  upd_rec;
    logic [LEN_W-1:0]            rem_dec;
    logic signed [ACC_W-1:0]     scaled_val;
    logic signed [PROD_W-1:0]    samp_x;
    logic signed [PROD_W-1:0]    gain_x;
    logic [MASK_W-1:0]           mask;

    assign voice_ok  = 32'(voice_reg) < VOICES;
    assign vidx      = VW'(voice_reg);
    assign start_rec = '{position: addr_reg, remaining: len_reg, region_start: addr_reg,
                         region_length: len_reg, gain: gain_reg, flags: flags_reg};

    assign samp_x = {{(PROD_W - SAMPLE_W){sm_rdata[SAMPLE_W-1]}}, sm_rdata};
    assign gain_x = {{(PROD_W - GAIN_W){1'b0}}, vm_rdata.gain};
    // Floor division by 4096 is the arithmetic shift of the product.
    assign scaled_val = {{(ACC_W - PROD_W + GAIN_SHIFT){prod_reg[PROD_W-1]}},
                         prod_reg[PROD_W-1:GAIN_SHIFT]};
    assign rem_dec = (vm_rdata.remaining != '0) ? vm_rdata.remaining - LEN_W'(1) : '0;

    for (genvar g = 0; g < MASK_W; g++)
    begin : g_mask
        if (g < VOICES)
        begin : g_on
            assign mask[g] = playing_reg[g];
        end
        else
        begin : g_off
            assign mask[g] = 1'b0;
        end
    end

    assign res = '{mix_left_out: acc_l_reg, mix_right_out: acc_r_reg, playing_mask: mask};

    always_comb
    begin
        state_next   = state_reg;
        playing_next = playing_reg;
        op_next      = op_reg;
        voice_next   = voice_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        gain_next    = gain_reg;
        flags_next   = flags_reg;
        word_next    = word_reg;
        acc_l_next   = acc_l_reg;
        acc_r_next   = acc_r_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        red_next     = red_reg;
        red_sub_next = red_sub_reg;
        red_cnt_next = red_cnt_reg;
        prod_next    = prod_reg;
        upd_rec      = vm_rdata;

        item.ready = (state_reg == S_IDLE);
        sm_we      = 1'b0;
        sm_waddr   = AW'(red_reg);
        sm_wdata   = word_reg;
        sm_re      = 1'b0;
        sm_raddr   = AW'(red_reg);
        vm_we      = 1'b0;
        vm_waddr   = idx_reg[VW-1:0];
        vm_wdata   = vm_rdata;
        vm_re      = 1'b0;
        vm_raddr   = idx_reg[VW-1:0];
        res_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next    = item.op;
                    voice_next = item.voice;
                    addr_next  = item.address;
                    len_next   = (item.length > LEN_MAX) ? LEN_MAX : item.length;
                    gain_next  = item.gain;
                    flags_next = '{loop: item.looping, right: item.route_right,
                                   left: item.route_left};
                    word_next  = item.sample_word;
                    if (item.op == OP_MIX)
                    begin
                        acc_l_next = item.mix_left_in;
                        acc_r_next = item.mix_right_in;
                    end
                    else
                    begin
                        acc_l_next = '0;
                        acc_r_next = '0;
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_MIX:
                    begin
                        idx_next = '0;
                        if (32'(active_voices) > VOICES)
                        begin
                            n_next = CW'(VOICES);
                        end
                        else
                        begin
                            n_next = CW'(active_voices);
                        end
                        state_next = S_SCAN;
                    end
                    OP_WRITE:
                    begin
                        red_next     = addr_reg;
                        red_sub_next = RED_TOP;
                        red_cnt_next = SW'(MOD_STEPS);
                        state_next   = (MOD_STEPS == 0) ? S_SWRITE : S_REDUCE;
                    end
                    OP_START:
                    begin
                        if (voice_ok)
                        begin
                            vm_we              = 1'b1;
                            vm_waddr           = vidx;
                            vm_wdata           = start_rec;
                            playing_next[vidx] = (len_reg != '0);
                        end
                        state_next = S_RESULT;
                    end
                    OP_STOP:
                    begin
                        if (voice_ok)
                        begin
                            playing_next[vidx] = 1'b0;
                        end
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (idx_reg >= n_reg)
                begin
                    state_next = S_RESULT;
                end
                else if (playing_reg[idx_reg[VW-1:0]])
                begin
                    vm_re      = 1'b1;
                    state_next = S_VWAIT;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_VWAIT:
            begin
                if (MOD_STEPS == 0)
                begin
                    sm_re      = 1'b1;
                    sm_raddr   = AW'(vm_rdata.position);
                    state_next = S_SDATA;
                end
                else
                begin
                    red_next     = vm_rdata.position;
                    red_sub_next = RED_TOP;
                    red_cnt_next = SW'(MOD_STEPS);
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (red_reg >= red_sub_reg)
                begin
                    red_next = red_reg - red_sub_reg;
                end
                red_sub_next = red_sub_reg >> 1;
                red_cnt_next = red_cnt_reg - SW'(1);
                if (red_cnt_reg == SW'(1))
                begin
                    state_next = (op_reg == OP_WRITE) ? S_SWRITE : S_SREQ;
                end
            end
            S_SREQ:
            begin
                sm_re      = 1'b1;
                state_next = S_SDATA;
            end
            S_SWRITE:
            begin
                sm_we      = 1'b1;
                state_next = S_RESULT;
            end
            S_SDATA:
            begin
                prod_next  = samp_x * gain_x;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (vm_rdata.flags.left)
                begin
                    acc_l_next = acc_l_reg + scaled_val;
                end
                if (vm_rdata.flags.right)
                begin
                    acc_r_next = acc_r_reg + scaled_val;
                end
                upd_rec.position  = vm_rdata.position + ADDR_W'(1);
                upd_rec.remaining = rem_dec;
                if (rem_dec == '0)
                begin
                    if (vm_rdata.flags.loop && vm_rdata.region_length != '0)
                    begin
                        upd_rec.position  = vm_rdata.region_start;
                        upd_rec.remaining = vm_rdata.region_length;
                    end
                    else
                    begin
                        playing_next[idx_reg[VW-1:0]] = 1'b0;
                    end
                end
                // The write-back lands before the next voice read is issued, so no
                // read of this entry can see a stale record.
                vm_we      = 1'b1;
                vm_wdata   = upd_rec;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SCAN;
            end
            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            playing_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            playing_reg <= playing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        voice_reg   <= voice_next;
        addr_reg    <= addr_next;
        len_reg     <= len_next;
        gain_reg    <= gain_next;
        flags_reg   <= flags_next;
        word_reg    <= word_next;
        acc_l_reg   <= acc_l_next;
        acc_r_reg   <= acc_r_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        red_reg     <= red_next;
        red_sub_reg <= red_sub_next;
        red_cnt_reg <= red_cnt_next;
        prod_reg    <= prod_next;
    end

endmodule

>>> src/multi_voice_sample_mixer_top.sv
`timescale 1ns / 1ps
// Channel   Direction   Handshake     Payload
// item      in          valid/ready   op, voice, address, length, gain, routing, looping,
//                                     sample_word, mix_left_in, mix_right_in
// result    out         valid/ready   mix_left_out, mix_right_out, playing_mask
// cfg       in          cfg_we        cfg_wdata (active_voices)
//
// One request at a time; a mix frame scans the active voices one voice at a time and reads a
// sample only for each voice that is playing. A depth that is not a power of two below 65536
// adds a restoring address reduction to a write and to each sample read.
// Reset clears the playing bits and the state machine; neither memory is cleared.
// A full output register holds the sequencer, and with it the input, until its result leaves.
`include "assert_macros.svh"
module multi_voice_sample_mixer_top #(
    parameter int VOICES = 8,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mvsm_in_if.sink                       item,
    mvsm_out_if.source                    result,
    input  logic                          cfg_we,
    input  logic [mvsm_pkg::CFG_W-1:0]    cfg_wdata
);
    import mvsm_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);

    logic [CFG_W-1:0]     active_reg, active_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg, out_data_next;

    logic                 sm_we;
    logic [AW-1:0]        sm_waddr;
    logic [SAMPLE_W-1:0]  sm_wdata;
    logic                 sm_re;
    logic [AW-1:0]        sm_raddr;
    logic [SAMPLE_W-1:0]  sm_rdata;
    logic                 vm_we;
    logic [VW-1:0]        vm_waddr;
    voice_rec_t           vm_wdata;
    logic                 vm_re;
    logic [VW-1:0]        vm_raddr;
    voice_rec_t           vm_rdata;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res_data;

    mvsm_sample_mem #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_mem (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    mvsm_voice_mem #(
        .VOICES (VOICES)
    ) u_voice_mem (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .re    (vm_re),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    mvsm_engine #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .active_voices (active_reg),
        .sm_we         (sm_we),
        .sm_waddr      (sm_waddr),
        .sm_wdata      (sm_wdata),
        .sm_re         (sm_re),
        .sm_raddr      (sm_raddr),
        .sm_rdata      (sm_rdata),
        .vm_we         (vm_we),
        .vm_waddr      (vm_waddr),
        .vm_wdata      (vm_wdata),
        .vm_re         (vm_re),
        .vm_raddr      (vm_raddr),
        .vm_rdata      (vm_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res_data)
    );

    // The output register takes a new result when empty or when its result leaves this cycle.
    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        active_next    = cfg_we ? cfg_wdata : active_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= ACTIVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.mix_left_out  = out_data_reg.mix_left_out;
    assign result.mix_right_out = out_data_reg.mix_right_out;
    assign result.playing_mask  = out_data_reg.playing_mask;

    `ASSERT_NEVER(a_vmem_rw_overlap, clk, rst_n, vm_we && vm_re, "voice memory read and write overlap")
    `ASSERT_NEVER(a_smem_rw_overlap, clk, rst_n, sm_we && sm_re, "sample memory read and write overlap")
    `ASSERT_PROP(a_busy_after_accept, clk, rst_n, item.valid && item.ready |=> !item.ready, "request accepted while busy")
    `ASSERT_PROP(a_result_held, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res_data), "pending result changed while output full")

endmodule

>>> dv/multi_voice_sample_mixer_top_tb.sv
`timescale 1ns / 1ps
module multi_voice_sample_mixer_top_tb;
    import mvsm_pkg::*;

    localparam int NUM_VOICES   = 8;
    localparam int MEM_WORDS    = 65536;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_CYCLES = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 750;
    localparam int BANK_WORDS   = 256;
    localparam logic [ADDR_W-1:0] BANK_BASE = 16'hFF80;

    typedef struct {
        op_t                      op;
        logic [VOICE_W-1:0]       voice;
        logic [ADDR_W-1:0]        address;
        logic [LEN_W-1:0]         length;
        logic [GAIN_W-1:0]        gain;
        logic                     route_left;
        logic                     route_right;
        logic                     looping;
        logic signed [SAMPLE_W-1:0] sample_word;
        logic signed [ACC_W-1:0]  mix_left_in;
        logic signed [ACC_W-1:0]  mix_right_in;
    } mix_req_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    mvsm_in_if  item_ch ();
    mvsm_out_if result_ch ();

    multi_voice_sample_mixer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mixer state as the testbench expects it to be.
    logic signed [SAMPLE_W-1:0] pcm_mem [MEM_WORDS];
    bit                         pcm_written [MEM_WORDS];
    logic [ADDR_W-1:0]          v_pos [NUM_VOICES];
    logic [LEN_W-1:0]           v_rem [NUM_VOICES];
    logic [ADDR_W-1:0]          v_start [NUM_VOICES];
    logic [LEN_W-1:0]           v_len [NUM_VOICES];
    logic [GAIN_W-1:0]          v_gain [NUM_VOICES];
    voice_flags_t               v_flags [NUM_VOICES];
    logic [MASK_W-1:0]          playing;
    logic [CFG_W-1:0]           active_cfg;

    result_t pending_mixes [$];
    result_t want;

    bit steady;
    bit stall_request;
    int fault_count;
    int quiet_cycles;
    int items_sent;
    int frames_mixed;
    int voice_ends;
    int loop_restarts;
    int words_patched;
    int cfg_writes;
    int held_cycles;

    function automatic result_t compute_mix_result(input mix_req_t r);
        result_t           res;
        int                scan;
        longint            prod;
        logic [ACC_W-1:0]  part;
        logic [LEN_W-1:0]  len;
        res.mix_left_out  = '0;
        res.mix_right_out = '0;
        case (r.op)
            OP_MIX:
            begin
                scan = (active_cfg > NUM_VOICES) ? NUM_VOICES : int'(active_cfg);
                res.mix_left_out  = r.mix_left_in;
                res.mix_right_out = r.mix_right_in;
                for (int i = 0; i < scan; i++)
                begin
                    if (playing[i])
                    begin
                        // Arithmetic shift gives floor for negative products.
                        prod = longint'(pcm_mem[v_pos[i]]) * longint'(v_gain[i]);
                        part = ACC_W'(prod >>> GAIN_SHIFT);
                        if (v_flags[i].left)
                            res.mix_left_out += part;
                        if (v_flags[i].right)
                            res.mix_right_out += part;
                        v_pos[i] += 1'b1;
                        if (v_rem[i] != 0)
                            v_rem[i] -= 1'b1;
                        if (v_rem[i] == 0)
                        begin
                            if (v_flags[i].loop && v_len[i] != 0)
                            begin
                                v_pos[i] = v_start[i];
                                v_rem[i] = v_len[i];
                                loop_restarts++;
                            end
                            else
                            begin
                                playing[i] = 1'b0;
                                voice_ends++;
                            end
                        end
                    end
                end
                frames_mixed++;
            end
            OP_WRITE:
            begin
                pcm_mem[r.address]     = r.sample_word;
                pcm_written[r.address] = 1'b1;
            end
            OP_START:
            begin
                len = (r.length > LEN_MAX) ? LEN_MAX : r.length;
                v_start[r.voice] = r.address;
                v_len[r.voice]   = len;
                v_pos[r.voice]   = r.address;
                v_rem[r.voice]   = len;
                v_gain[r.voice]  = r.gain;
                v_flags[r.voice] = '{loop: r.looping, right: r.route_right, left: r.route_left};
                playing[r.voice] = (len != 0);
            end
            default:
                playing[r.voice] = 1'b0;
        endcase
        res.playing_mask = playing;
        return res;
    endfunction

    function automatic mix_req_t random_request();
        mix_req_t r;
        r.op           = op_t'($urandom_range(3));
        r.voice        = VOICE_W'($urandom_range(NUM_VOICES - 1));
        r.address      = ADDR_W'($urandom);
        r.length       = LEN_W'($urandom);
        r.gain         = GAIN_W'($urandom);
        r.route_left   = 1'($urandom);
        r.route_right  = 1'($urandom);
        r.looping      = 1'($urandom);
        r.sample_word  = SAMPLE_W'($urandom);
        r.mix_left_in  = ACC_W'($urandom);
        r.mix_right_in = ACC_W'($urandom);
        return r;
    endfunction

    // Entered and left at a falling edge; unless steady, valid may drop between requests.
    task automatic send_request(input mix_req_t r);
        while (!steady && $urandom_range(99) < 11)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.op           <= r.op;
        item_ch.voice        <= r.voice;
        item_ch.address      <= r.address;
        item_ch.length       <= r.length;
        item_ch.gain         <= r.gain;
        item_ch.route_left   <= r.route_left;
        item_ch.route_right  <= r.route_right;
        item_ch.looping      <= r.looping;
        item_ch.sample_word  <= r.sample_word;
        item_ch.mix_left_in  <= r.mix_left_in;
        item_ch.mix_right_in <= r.mix_right_in;
        item_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        pending_mixes.push_back(compute_mix_result(r));
        items_sent++;
        @(negedge clk);
    endtask

    // Any playing voice that would read a never-written word gets that word written first.
    task automatic send_frame(input logic signed [ACC_W-1:0] left_in,
                              input logic signed [ACC_W-1:0] right_in);
        mix_req_t r;
        int       scan;
        scan = (active_cfg > NUM_VOICES) ? NUM_VOICES : int'(active_cfg);
        for (int i = 0; i < scan; i++)
        begin
            if (playing[i] && !pcm_written[v_pos[i]])
            begin
                r         = random_request();
                r.op      = OP_WRITE;
                r.address = v_pos[i];
                send_request(r);
                words_patched++;
            end
        end
        r              = random_request();
        r.op           = OP_MIX;
        r.mix_left_in  = left_in;
        r.mix_right_in = right_in;
        send_request(r);
    endtask

    task automatic write_word(input logic [ADDR_W-1:0] addr,
                              input logic signed [SAMPLE_W-1:0] word);
        mix_req_t r;
        r             = random_request();
        r.op          = OP_WRITE;
        r.address     = addr;
        r.sample_word = word;
        send_request(r);
    endtask

    task automatic start_voice(input logic [VOICE_W-1:0] v, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] len, input logic [GAIN_W-1:0] g,
                               input logic to_left, input logic to_right, input logic lp);
        mix_req_t r;
        r             = random_request();
        r.op          = OP_START;
        r.voice       = v;
        r.address     = addr;
        r.length      = len;
        r.gain        = g;
        r.route_left  = to_left;
        r.route_right = to_right;
        r.looping     = lp;
        send_request(r);
    endtask

    task automatic stop_voice(input logic [VOICE_W-1:0] v);
        mix_req_t r;
        r       = random_request();
        r.op    = OP_STOP;
        r.voice = v;
        send_request(r);
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_mixes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Only called once the block has gone idle.
    task automatic set_active_voices(input logic [CFG_W-1:0] count);
        cfg_wdata <= count;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we     <= 1'b0;
        active_cfg  = count;
        cfg_writes++;
    endtask

    task automatic test_idle_frames();
        send_frame(32'sh1234_5678, -32'sd1);
        stop_voice(3'd5);
        send_frame(32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_directed_voices();
        write_word(16'h0000, 16'sh7FFF);
        write_word(16'h0001, 16'sh8000);
        write_word(16'h0002, -16'sd1);
        write_word(16'h0003, 16'sd1);
        write_word(16'hFFFE, 16'sh7FFF);
        write_word(16'hFFFF, 16'sh8000);
        start_voice(3'd0, 16'h0000, 17'd4, 16'd4096, 1'b1, 1'b0, 1'b0);
        // Crosses the top of the address space and loops.
        start_voice(3'd1, 16'hFFFE, 17'd4, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        // A zero length region leaves the voice stopped.
        start_voice(3'd2, 16'h0002, 17'd0, 16'h1000, 1'b1, 1'b1, 1'b1);
        // Oversized length saturates; with no routing the voice only advances.
        start_voice(3'd3, 16'h0001, 17'h1FFFF, 16'd1, 1'b0, 1'b0, 1'b0);
        // A sample of -1 at the smallest nonzero gain floors to -1.
        start_voice(3'd4, 16'h0002, 17'd1, 16'd1, 1'b1, 1'b0, 1'b0);
        send_frame(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_frame(32'sd0, 32'sd0);
        start_voice(3'd0, 16'h0002, 17'd2, 16'h8000, 1'b0, 1'b1, 1'b1);
        send_frame(ACC_W'($urandom), ACC_W'($urandom));
        stop_voice(3'd1);
        stop_voice(3'd1);
        send_frame(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_frame(ACC_W'($urandom), ACC_W'($urandom));
        stop_voice(3'd3);
        send_frame(32'sd0, 32'sd0);
    endtask

    task automatic test_active_count();
        logic [CFG_W-1:0] settings [5] = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd8};
        for (int k = 0; k < 3 + NUM_VOICES; k++)
            write_word(16'h4000 + ADDR_W'(k), SAMPLE_W'($urandom));
        for (int v = 0; v < NUM_VOICES; v++)
            start_voice(VOICE_W'(v), 16'h4000 + ADDR_W'(v), 17'd3, GAIN_W'($urandom),
                        1'($urandom), 1'($urandom), 1'b1);
        foreach (settings[s])
        begin
            wait_idle();
            set_active_voices(settings[s]);
            repeat (3) send_frame(ACC_W'($urandom), ACC_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        mix_req_t r;
        int       pick;
        int       sel;
        for (int k = 0; k < BANK_WORDS; k++)
            write_word(BANK_BASE + ADDR_W'(k), SAMPLE_W'($urandom));
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 220 == 219)
            begin
                wait_idle();
                if ($urandom_range(3) == 0)
                    set_active_voices(CFG_W'($urandom_range(15)));
                else
                    set_active_voices(CFG_W'($urandom_range(1, NUM_VOICES)));
            end
            steady = (n >= 400 && n < 600);
            pick   = $urandom_range(99);
            r      = random_request();
            if ($urandom_range(9) == 0)
                r.mix_left_in = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            if (pick < 48)
                send_frame(r.mix_left_in, r.mix_right_in);
            else if (pick < 68)
            begin
                r.op = OP_WRITE;
                if ($urandom_range(9) < 6)
                    r.address = BANK_BASE + ADDR_W'($urandom_range(BANK_WORDS - 1));
                send_request(r);
            end
            else if (pick < 92)
            begin
                r.op = OP_START;
                sel  = $urandom_range(99);
                if (sel < 75)
                begin
                    r.address = BANK_BASE + ADDR_W'($urandom_range(200));
                    r.length  = LEN_W'($urandom_range(1, 48));
                end
                else if (sel < 95)
                    r.length = LEN_W'($urandom_range(12));
                else if (sel < 97)
                    r.length = 17'h1FFFF;
                case ($urandom_range(7))
                    0: r.gain = 16'd4096;
                    1: r.gain = 16'hFFFF;
                    2: r.gain = 16'd0;
                    default: ;
                endcase
                send_request(r);
            end
            else
            begin
                r.op = OP_STOP;
                send_request(r);
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        mix_req_t r;
        wait_idle();
        set_active_voices(ACTIVE_RESET);
        for (int v = 0; v < 4; v++)
            start_voice(VOICE_W'(v), BANK_BASE + ADDR_W'(16 * v), 17'd20, GAIN_W'($urandom),
                        1'b1, 1'b1, 1'b1);
        stall_request = 1'b1;
        for (int n = 0; n < 30; n++)
        begin
            r = random_request();
            if (r.op == OP_START)
                r.address = BANK_BASE + ADDR_W'($urandom_range(100));
            if (r.op == OP_MIX)
                send_frame(r.mix_left_in, r.mix_right_in);
            else
                send_request(r);
        end
    endtask

    // Result side: ready with random gaps, plus one long hold-off on request.
    initial
    begin : result_receiver
        int held;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request    = 1'b0;
                result_ch.ready <= 1'b0;
                for (held = 1; held < STALL_CYCLES; held++)
                    @(negedge clk);
                held_cycles = held;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_mixes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%t: result with nothing outstanding: L=%h R=%h mask=%h", $time,
                             result_ch.mix_left_out, result_ch.mix_right_out,
                             result_ch.playing_mask);
            end
            else
            begin
                want = pending_mixes.pop_front();
                if (result_ch.mix_left_out !== want.mix_left_out ||
                    result_ch.mix_right_out !== want.mix_right_out ||
                    result_ch.playing_mask !== want.playing_mask)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%t: expected L=%h R=%h mask=%h, got L=%h R=%h mask=%h", $time,
                                 want.mix_left_out, want.mix_right_out, want.playing_mask,
                                 result_ch.mix_left_out, result_ch.mix_right_out,
                                 result_ch.playing_mask);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("multi_voice_sample_mixer_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_ch.valid        = 1'b0;
        item_ch.op           = OP_MIX;
        item_ch.voice        = '0;
        item_ch.address      = '0;
        item_ch.length       = '0;
        item_ch.gain         = '0;
        item_ch.route_left   = 1'b0;
        item_ch.route_right  = 1'b0;
        item_ch.looping      = 1'b0;
        item_ch.sample_word  = '0;
        item_ch.mix_left_in  = '0;
        item_ch.mix_right_in = '0;
        steady               = 1'b0;
        stall_request        = 1'b0;
        playing              = '0;
        active_cfg           = ACTIVE_RESET;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            v_pos[v]   = '0;
            v_rem[v]   = '0;
            v_start[v] = '0;
            v_len[v]   = '0;
            v_gain[v]  = '0;
            v_flags[v] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_frames();
        test_directed_voices();
        test_active_count();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();

        $display("Ran %0d requests: %0d mix frames, %0d voice ends, %0d loop restarts.",
                 items_sent, frames_mixed, voice_ends, loop_restarts);
        $display("%0d active-count writes, %0d words filled ahead of frames, %0d-cycle output hold.",
                 cfg_writes, words_patched, held_cycles);
        if (fault_count == 0)
            $display("multi_voice_sample_mixer_top_tb: clean");
        else
            $display("multi_voice_sample_mixer_top_tb: errors");
        $finish;
    end

endmodule
